>>> src/pdh_pkg.sv
// Shared types, constants and a helper function of the pair distance histogram unit.
package pdh_pkg;

	localparam int MAX_PARTICLES = 2048;
	localparam int DIMENSIONS    = 6;
	localparam int DIST_BINS     = 1024;
	localparam int CONTACT_BINS  = 64;
	localparam int IN_COORDS     = 6;

	localparam int COORD_W = 24;
	localparam int RAD_W   = 20;
	localparam int RSUM_W  = RAD_W + 1;
	localparam int BIDX_W  = 10;
	localparam int CNT_W   = $clog2(MAX_PARTICLES + 1);
	localparam int PIDX_W  = $clog2(MAX_PARTICLES);
	localparam int CADDR_W = $clog2(MAX_PARTICLES * DIMENSIONS);
	localparam int AX_W    = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
	localparam int SUM_W   = 2 * COORD_W + AX_W;
	localparam int DBIN_W  = $clog2(DIST_BINS);
	localparam int CBIN_W  = (CONTACT_BINS > 1) ? $clog2(CONTACT_BINS) : 1;
	localparam int CLR_N   = (DIST_BINS > CONTACT_BINS) ? DIST_BINS : CONTACT_BINS;
	localparam int CLR_W   = $clog2(CLR_N);
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int LIMB_W  = 21;
	localparam int OP_W    = 3 * LIMB_W;

	localparam logic [23:0] BOX_RESET   = 24'd276393;
	localparam logic [6:0]  LIMIT_RESET = 7'd50;
	localparam logic [31:0] CONTACT_OFS = 32'd1000;

	// Configuration register indexes.
	localparam logic [1:0] CFG_BOX   = 2'd0;
	localparam logic [1:0] CFG_LIMIT = 2'd1;

	// Request codes on the input port.
	localparam logic [2:0] REQ_ADD     = 3'd0;
	localparam logic [2:0] REQ_RD_DIST = 3'd1;
	localparam logic [2:0] REQ_RD_CONT = 3'd2;
	localparam logic [2:0] REQ_SNAP    = 3'd3;
	localparam logic [2:0] REQ_CLEAR   = 3'd4;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ADD,
		OP_RD_DIST,
		OP_RD_CONT,
		OP_SNAP,
		OP_CLEAR
	} pdh_op_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [23:0] coord_0;
		logic [23:0] coord_1;
		logic [23:0] coord_2;
		logic [23:0] coord_3;
		logic [23:0] coord_4;
		logic [23:0] coord_5;
		logic [19:0] radius;
		logic [9:0]  bin_index;
	} pdh_req_t;

	typedef struct packed {
		logic [31:0] bin_count;
		logic [63:0] power_sum;
		logic [11:0] particles_stored;
		logic        dropped_flag;
	} pdh_result_t;

	typedef struct packed {
		pdh_op_t                            op;
		logic [IN_COORDS-1:0][COORD_W-1:0]  coord;
		logic [RAD_W-1:0]                   radius;
		logic [BIDX_W-1:0]                  bin_index;
	} pdh_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} pdh_unit_stat_t;

	function automatic logic [31:0] pdh_bump(input logic [31:0] c);
		pdh_bump = (c > 32'hFFFF_FFFD) ? 32'hFFFF_FFFF : c + 32'd2;
	endfunction

endpackage

>>> src/pdh_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module pdh_isqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [63:0]             value,
	output pdh_pkg::pdh_unit_stat_t stat,
	output logic [31:0]             root
);
	import pdh_pkg::*;

	logic [63:0] val_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  step_q;
	logic        done_q;
	logic [34:0] rem_n;
	logic [34:0] trial;
	logic        ge;

	always_comb begin
		rem_n = {rem_q[32:0], val_q[63:62]};
		trial = {1'b0, root_q, 2'b01};
		ge    = (rem_n >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= 6'd32;
			done_q <= 1'b0;
		end else if (step_q != '0) begin
			step_q <= step_q - 6'd1;
			done_q <= (step_q == 6'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (step_q != '0) begin
			val_q  <= {val_q[61:0], 2'b00};
			rem_q  <= ge ? (rem_n - trial) : rem_n;
			root_q <= {root_q[30:0], ge};
		end
	end

	assign stat.busy = (step_q != '0);
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

>>> src/pdh_div.sv
// Restoring divider for the contact bin, one quotient bit per cycle.
module pdh_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [31:0]                  dividend,
	input  logic [pdh_pkg::RSUM_W-1:0]   divisor,
	output pdh_pkg::pdh_unit_stat_t      stat,
	output logic [31:0]                  quot
);
	import pdh_pkg::*;

	logic [31:0]       dq_q;
	logic [RSUM_W:0]   rem_q;
	logic [RSUM_W-1:0] div_q;
	logic [5:0]        step_q;
	logic              done_q;
	logic [RSUM_W:0]   rem_n;
	logic              ge;

	always_comb begin
		rem_n = {rem_q[RSUM_W-1:0], dq_q[31]};
		ge    = (rem_n >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= 6'd32;
			done_q <= 1'b0;
		end else if (step_q != '0) begin
			step_q <= step_q - 6'd1;
			done_q <= (step_q == 6'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (step_q != '0) begin
			dq_q  <= {dq_q[30:0], ge};
			rem_q <= ge ? (rem_n - {1'b0, div_q}) : rem_n;
		end
	end

	assign stat.busy = (step_q != '0);
	assign stat.done = done_q;
	assign quot      = dq_q;

endmodule

>>> src/pdh_front.sv
// Front end: takes items, decodes the request and queues commands for the back end.
module pdh_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pdh_pkg::pdh_req_t req,
	input  logic              hold,
	output logic              busy,
	output logic              cmd_valid,
	output pdh_pkg::pdh_cmd_t cmd,
	input  logic              cmd_pop
);
	import pdh_pkg::*;

	pdh_cmd_t          q_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   fill_q;
	pdh_cmd_t          dec;
	logic              push;
	logic              pop;

	always_comb begin
		dec.coord[0]  = req.coord_0;
		dec.coord[1]  = req.coord_1;
		dec.coord[2]  = req.coord_2;
		dec.coord[3]  = req.coord_3;
		dec.coord[4]  = req.coord_4;
		dec.coord[5]  = req.coord_5;
		dec.radius    = req.radius;
		dec.bin_index = req.bin_index;
		case (req.req_type)
			REQ_ADD:     dec.op = OP_ADD;
			REQ_RD_DIST: dec.op = OP_RD_DIST;
			REQ_RD_CONT: dec.op = OP_RD_CONT;
			REQ_SNAP:    dec.op = OP_SNAP;
			REQ_CLEAR:   dec.op = OP_CLEAR;
			default:     dec.op = OP_NOP;
		endcase
	end

	assign busy      = (fill_q == (QPTR_W+1)'(QDEPTH)) || hold;
	assign push      = start && !busy;
	assign cmd_valid = (fill_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= dec;
		end
	end

endmodule

>>> src/pdh_back.sv
// Back end: particle store, pair datapath, histogram memories and result register.
module pdh_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [23:0]          box_length,
	input  logic [6:0]           contact_bin_limit,
	input  logic                 cmd_valid,
	input  pdh_pkg::pdh_cmd_t    cmd,
	output logic                 cmd_pop,
	output logic                 init_clr,
	output logic                 result_valid,
	output pdh_pkg::pdh_result_t result
);
	import pdh_pkg::*;

	typedef enum logic [22:0] {
		ST_INIT    = 23'h000001,
		ST_IDLE    = 23'h000002,
		ST_AX_RD   = 23'h000004,
		ST_AX_SEP  = 23'h000008,
		ST_AX_SQ   = 23'h000010,
		ST_DGO     = 23'h000020,
		ST_DWAIT   = 23'h000040,
		ST_DH_RD   = 23'h000080,
		ST_DH_WR   = 23'h000100,
		ST_CGO     = 23'h000200,
		ST_CWAIT   = 23'h000400,
		ST_VGO     = 23'h000800,
		ST_VWAIT   = 23'h001000,
		ST_CH_RD   = 23'h002000,
		ST_CH_WR   = 23'h004000,
		ST_MSET    = 23'h008000,
		ST_MUL     = 23'h010000,
		ST_MNEXT   = 23'h020000,
		ST_STORE   = 23'h040000,
		ST_RD      = 23'h080000,
		ST_RD_WAIT = 23'h100000,
		ST_CLR     = 23'h200000,
		ST_RESP    = 23'h400000
	} pdh_state_t;

	pdh_state_t state_q;

	logic [COORD_W-1:0] coord_mem  [MAX_PARTICLES*DIMENSIONS];
	logic [RAD_W-1:0]   radius_mem [MAX_PARTICLES];
	logic [31:0]        dist_mem   [DIST_BINS];
	logic [31:0]        cont_mem   [CONTACT_BINS];

	pdh_cmd_t           cmd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   j_q;
	logic [AX_W-1:0]    k_q;
	logic [CADDR_W-1:0] ptr_q;
	logic [CLR_W-1:0]   clr_q;
	logic [63:0]        acc_q;
	logic               drop_q;
	logic [31:0]        bin_res_q;
	logic               res_valid_q;
	pdh_result_t        result_q;

	logic [COORD_W-1:0] coord_rd_q;
	logic [RAD_W-1:0]   radius_rd_q;
	logic [31:0]        dist_rd_q;
	logic [31:0]        cont_rd_q;
	logic [COORD_W-1:0] a_q;
	logic [SUM_W-1:0]   s_q;
	logic [RSUM_W-1:0]  rsum_q;
	logic [DBIN_W-1:0]  bin_q;
	logic [CBIN_W-1:0]  cbin_q;
	logic [OP_W-1:0]    opa_q;
	logic [OP_W-1:0]    opb_q;
	logic [2*OP_W-1:0]  prod_q;
	logic [1:0]         li_q;
	logic [1:0]         lj_q;
	logic [1:0]         mph_q;

	pdh_unit_stat_t     sq_stat;
	pdh_unit_stat_t     dv_stat;
	logic               sq_start;
	logic [63:0]        sq_val;
	logic [31:0]        sq_root;
	logic               dv_start;
	logic [31:0]        dv_quot;

	logic [COORD_W-1:0] own_coord;
	logic [26:0]        sep;
	logic [26:0]        sep2;
	logic [26:0]        box27;
	logic [26:0]        sep_abs;
	logic [47:0]        sq;
	logic               c_ok;
	logic [6:0]         lim;
	logic [31:0]        m_ofs;
	logic [LIMB_W-1:0]  limb_a;
	logic [LIMB_W-1:0]  limb_b;
	logic [2*LIMB_W-1:0] pp;
	logic [2*OP_W-1:0]  pp_sh;
	logic [2:0]         lsum;
	logic [64:0]        acc_sum;
	logic               last_ax;

	function automatic logic [COORD_W-1:0] coord_at(input pdh_cmd_t c,
			input logic [AX_W-1:0] k);
		logic [COORD_W-1:0] r;
		r = '0;
		for (int i = 0; i < IN_COORDS; i++) begin
			if (int'(k) == i) begin
				r = c.coord[i];
			end
		end
		return r;
	endfunction

	function automatic logic [LIMB_W-1:0] limb(input logic [OP_W-1:0] op,
			input logic [1:0] idx);
		logic [LIMB_W-1:0] r;
		case (idx)
			2'd0:    r = op[LIMB_W-1:0];
			2'd1:    r = op[2*LIMB_W-1:LIMB_W];
			default: r = op[3*LIMB_W-1:2*LIMB_W];
		endcase
		return r;
	endfunction

	pdh_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (sq_val),
		.stat   (sq_stat),
		.root   (sq_root)
	);

	pdh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (sq_root),
		.divisor  (rsum_q),
		.stat     (dv_stat),
		.quot     (dv_quot)
	);

	// Minimum-image separation on one axis.
	always_comb begin
		own_coord = coord_at(cmd_q, k_q);
		box27     = {3'b000, box_length};
		sep       = {3'b000, own_coord} - {3'b000, coord_rd_q};
		if ($signed({sep[25:0], 1'b0}) >= $signed(box27)) begin
			sep2 = sep - box27;
		end else if ($signed({sep[25:0], 1'b0}) <= -$signed(box27)) begin
			sep2 = sep + box27;
		end else begin
			sep2 = sep;
		end
		sep_abs = sep2[26] ? (27'd0 - sep2) : sep2;
	end

	always_comb begin
		sq      = a_q * a_q;
		c_ok    = (rsum_q != '0) && (s_q[SUM_W-1:42] == '0);
		lim     = (contact_bin_limit > 7'(CONTACT_BINS)) ? 7'(CONTACT_BINS)
			: contact_bin_limit;
		m_ofs   = dv_quot - CONTACT_OFS;
		limb_a  = limb(opa_q, li_q);
		limb_b  = limb(opb_q, lj_q);
		pp      = limb_a * limb_b;
		lsum    = {1'b0, li_q} + {1'b0, lj_q};
		case (lsum)
			3'd0:    pp_sh = (2*OP_W)'(pp);
			3'd1:    pp_sh = (2*OP_W)'(pp) << LIMB_W;
			3'd2:    pp_sh = (2*OP_W)'(pp) << (2*LIMB_W);
			3'd3:    pp_sh = (2*OP_W)'(pp) << (3*LIMB_W);
			default: pp_sh = (2*OP_W)'(pp) << (4*LIMB_W);
		endcase
		acc_sum = {1'b0, acc_q} + 65'(prod_q[2*OP_W-1:70]);
		last_ax = (k_q == AX_W'(DIMENSIONS - 1));
	end

	assign sq_start = (state_q == ST_DGO) || (state_q == ST_CGO);
	assign sq_val   = (state_q == ST_DGO) ? ((64'(s_q) * 64'd625) >> 28)
		: (64'(s_q) * 64'd4000000);
	assign dv_start = (state_q == ST_VGO);
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign init_clr = (state_q == ST_INIT);

	// Store memories.
	always_ff @(posedge clk) begin
		if (state_q == ST_STORE) begin
			coord_mem[ptr_q] <= own_coord;
			if (last_ax) begin
				radius_mem[cnt_q[PIDX_W-1:0]] <= cmd_q.radius;
			end
		end
		coord_rd_q  <= coord_mem[ptr_q];
		radius_rd_q <= radius_mem[j_q[PIDX_W-1:0]];
	end

	// Distance histogram memory.
	always_ff @(posedge clk) begin
		if ((state_q == ST_INIT || state_q == ST_CLR) && (int'(clr_q) < DIST_BINS)) begin
			dist_mem[DBIN_W'(clr_q)] <= '0;
		end else if (state_q == ST_DH_WR) begin
			dist_mem[bin_q] <= pdh_bump(dist_rd_q);
		end
		dist_rd_q <= dist_mem[(state_q == ST_DH_RD) ? bin_q : DBIN_W'(cmd_q.bin_index)];
	end

	// Contact histogram memory.
	always_ff @(posedge clk) begin
		if ((state_q == ST_INIT || state_q == ST_CLR) && (int'(clr_q) < CONTACT_BINS)) begin
			cont_mem[CBIN_W'(clr_q)] <= '0;
		end else if (state_q == ST_CH_WR) begin
			cont_mem[cbin_q] <= pdh_bump(cont_rd_q);
		end
		cont_rd_q <= cont_mem[(state_q == ST_CH_RD) ? cbin_q : CBIN_W'(cmd_q.bin_index)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			j_q         <= '0;
			k_q         <= '0;
			ptr_q       <= '0;
			clr_q       <= '0;
			acc_q       <= '0;
			drop_q      <= 1'b0;
			li_q        <= '0;
			lj_q        <= '0;
			mph_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + CLR_W'(1);
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							OP_ADD: begin
								ptr_q <= '0;
								j_q   <= '0;
								k_q   <= '0;
								if (cnt_q == CNT_W'(MAX_PARTICLES)) begin
									drop_q  <= 1'b1;
									state_q <= ST_RESP;
								end else if (cnt_q == '0) begin
									state_q <= ST_STORE;
								end else begin
									state_q <= ST_AX_RD;
								end
							end
							OP_RD_DIST, OP_RD_CONT: state_q <= ST_RD;
							OP_SNAP: begin
								cnt_q   <= '0;
								acc_q   <= '0;
								state_q <= ST_RESP;
							end
							OP_CLEAR: begin
								cnt_q   <= '0;
								acc_q   <= '0;
								drop_q  <= 1'b0;
								clr_q   <= '0;
								state_q <= ST_CLR;
							end
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_AX_RD: begin
					ptr_q   <= ptr_q + CADDR_W'(1);
					state_q <= ST_AX_SEP;
				end
				ST_AX_SEP: state_q <= ST_AX_SQ;
				ST_AX_SQ: begin
					if (last_ax) begin
						k_q     <= '0;
						state_q <= ST_DGO;
					end else begin
						k_q     <= k_q + AX_W'(1);
						state_q <= ST_AX_RD;
					end
				end
				ST_DGO: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (sq_stat.done) begin
						if ((sq_root != '0) && (sq_root < 32'(DIST_BINS))) begin
							state_q <= ST_DH_RD;
						end else begin
							if (sq_root != '0) begin
								drop_q <= 1'b1;
							end
							state_q <= c_ok ? ST_CGO : ST_MSET;
						end
					end
				end
				ST_DH_RD: state_q <= ST_DH_WR;
				ST_DH_WR: state_q <= c_ok ? ST_CGO : ST_MSET;
				ST_CGO:   state_q <= ST_CWAIT;
				ST_CWAIT: begin
					if (sq_stat.done) begin
						state_q <= ST_VGO;
					end
				end
				ST_VGO: state_q <= ST_VWAIT;
				ST_VWAIT: begin
					if (dv_stat.done) begin
						if ((dv_quot >= CONTACT_OFS) && (m_ofs < 32'(lim))) begin
							state_q <= ST_CH_RD;
						end else begin
							state_q <= ST_MSET;
						end
					end
				end
				ST_CH_RD: state_q <= ST_CH_WR;
				ST_CH_WR: state_q <= ST_MSET;
				ST_MSET: begin
					li_q    <= '0;
					lj_q    <= '0;
					mph_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (lj_q == 2'd2) begin
						lj_q <= '0;
						if (li_q == 2'd2) begin
							li_q    <= '0;
							state_q <= ST_MNEXT;
						end else begin
							li_q <= li_q + 2'd1;
						end
					end else begin
						lj_q <= lj_q + 2'd1;
					end
				end
				ST_MNEXT: begin
					if (mph_q == 2'd2) begin
						acc_q <= acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
						k_q   <= '0;
						if (j_q + CNT_W'(1) == cnt_q) begin
							state_q <= ST_STORE;
						end else begin
							j_q     <= j_q + CNT_W'(1);
							state_q <= ST_AX_RD;
						end
					end else begin
						mph_q   <= mph_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_STORE: begin
					ptr_q <= ptr_q + CADDR_W'(1);
					if (last_ax) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= ST_RESP;
					end else begin
						k_q <= k_q + AX_W'(1);
					end
				end
				ST_RD:      state_q <= ST_RD_WAIT;
				ST_RD_WAIT: state_q <= ST_RESP;
				ST_CLR: begin
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= ST_RESP;
					end else begin
						clr_q <= clr_q + CLR_W'(1);
					end
				end
				ST_RESP: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_q     <= cmd;
					bin_res_q <= '0;
				end
			end
			ST_AX_RD: begin
				if (k_q == '0) begin
					s_q <= '0;
				end
			end
			ST_AX_SEP: a_q <= sep_abs[COORD_W-1:0];
			ST_AX_SQ: begin
				s_q    <= s_q + SUM_W'(sq);
				rsum_q <= RSUM_W'(cmd_q.radius) + RSUM_W'(radius_rd_q);
			end
			ST_DWAIT: bin_q <= sq_root[DBIN_W-1:0];
			ST_VWAIT: cbin_q <= m_ofs[CBIN_W-1:0];
			ST_MSET: begin
				opa_q  <= OP_W'(rsum_q);
				opb_q  <= OP_W'(rsum_q);
				prod_q <= '0;
			end
			ST_MUL: prod_q <= prod_q + pp_sh;
			ST_MNEXT: begin
				// Second pass forms the cube, third pass squares the cube.
				opa_q  <= prod_q[OP_W-1:0];
				opb_q  <= (mph_q == 2'd0) ? OP_W'(rsum_q) : prod_q[OP_W-1:0];
				prod_q <= '0;
			end
			ST_RD_WAIT: begin
				if (cmd_q.op == OP_RD_DIST) begin
					bin_res_q <= (32'(cmd_q.bin_index) < 32'(DIST_BINS)) ? dist_rd_q : '0;
				end else begin
					bin_res_q <= (32'(cmd_q.bin_index) < 32'(CONTACT_BINS)) ? cont_rd_q : '0;
				end
			end
			ST_RESP: begin
				result_q.bin_count        <= bin_res_q;
				result_q.power_sum        <= acc_q;
				result_q.particles_stored <= 12'(cnt_q);
				result_q.dropped_flag     <= drop_q;
			end
			default: begin
			end
		endcase
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PARTICLES))
		else $error("stored particle count above capacity");
	a_sq_free: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> !sq_stat.busy)
		else $error("square root started while busy");
	a_dv_free: assert property (@(posedge clk) disable iff (!arst_n)
		dv_start |-> !dv_stat.busy)
		else $error("divider started while busy");
	a_pair_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AX_RD) |-> (j_q < cnt_q))
		else $error("pair index beyond stored particles");
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");
`endif

endmodule

>>> src/pair_distance_histogram_unit.sv
// Top level of the pair distance histogram unit: configuration registers and block wiring.
// Every accepted item produces exactly one result, shown for one cycle with result_valid;
// the receiver cannot stall it. Items are taken while busy is low into a two-entry command
// queue. An add request works through each particle already stored, using the shared
// 32-step square root unit (up to twice per pair), the 32-step divider and the 27-step
// limb multiplier for the pair power term. Reads wait on a registered histogram read;
// clear all sweeps both histogram memories over 1024 entries. After reset busy stays high
// during a clearing pass over the histograms; configuration writes are taken at any time
// and are always ready.
module pair_distance_histogram_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pdh_pkg::pdh_req_t    req,
	output logic                 result_valid,
	output pdh_pkg::pdh_result_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_data
);
	import pdh_pkg::*;

	logic [23:0] box_q;
	logic [6:0]  limit_q;
	logic        cmd_valid;
	pdh_cmd_t    cmd;
	logic        cmd_pop;
	logic        init_clr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q   <= BOX_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BOX:   box_q   <= cfg_data;
				CFG_LIMIT: limit_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	pdh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.hold      (init_clr),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	pdh_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.box_length        (box_q),
		.contact_bin_limit (limit_q),
		.cmd_valid         (cmd_valid),
		.cmd               (cmd),
		.cmd_pop           (cmd_pop),
		.init_clr          (init_clr),
		.result_valid      (result_valid),
		.result            (result)
	);

endmodule
